/* sv/mbps_pkg.sv */
`default_nettype none

package mbps_pkg;

  // Window depth and the longest usable pattern.
  localparam int MAX_PATTERN = 32;
  localparam int PAT_BYTES   = 32;
  localparam int LEN_CAP     = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
  localparam int LEN_W       = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

  // Width of the byte position counter inside a region.
  localparam int OFFSET_BITS = 32;

  // Configuration register file geometry.
  localparam int DATA_W  = 64;
  localparam int NUM_REGS = 8;
  localparam int REG_W   = $clog2(NUM_REGS);
  localparam int ADDR_W  = REG_W + 3;

  // Register indexes.
  typedef enum logic [REG_W-1:0] {
    REG_PAT0   = 3'd0,
    REG_PAT1   = 3'd1,
    REG_PAT2   = 3'd2,
    REG_PAT3   = 3'd3,
    REG_MASK   = 3'd4,
    REG_LENGTH = 3'd5,
    REG_STRIDE = 3'd6,
    REG_BASE   = 3'd7
  } reg_idx_t;

  typedef logic [MAX_PATTERN-1:0][7:0] window_t;
  typedef logic [PAT_BYTES-1:0][7:0]   pattern_t;

  // Register contents as seen by the scan logic.
  typedef struct packed {
    pattern_t                 pattern;
    logic [PAT_BYTES-1:0]     mask;
    logic [5:0]               length;
    logic [15:0]              stride;
    logic [63:0]              base;
  } cfg_t;

  // Effective pattern length minus one: zero counts as one, and the length is
  // capped at the window depth.
  function automatic logic [LEN_W-1:0] len_m1(input logic [5:0] raw);
    logic [6:0] eff;
    eff = {1'b0, raw};
    if (eff == 7'd0) begin
      eff = 7'd1;
    end
    if (eff > 7'(LEN_CAP)) begin
      eff = 7'(LEN_CAP);
    end
    return LEN_W'(eff - 7'd1);
  endfunction

endpackage

`default_nettype wire

/* sv/masked_byte_pattern_scanner.sv */
// Masked byte pattern scanner.
// The input channel (in_valid, in_stall, data_byte, last_byte) carries the
// bytes of one memory region in address order, one per transaction; last_byte
// marks the final byte. The output channel (out_valid, out_stall, found,
// match_address) carries at most one transaction per region: found = 1 with
// the base plus start offset of the first match, or found = 0 at the last
// byte when nothing matched. Later bytes after a match give nothing.
// Throughput is one byte per cycle while in_stall is low: the window compare
// and the state update finish in the cycle a byte is taken; the result that
// byte causes shows in the next cycle. The single result register sets the
// limit: while it holds a result and out_stall is high, in_stall is high.
// The APB port holds the pattern, mask, length, stride and base; write it
// only between regions. Reset (synchronous, rst high) restores the register
// defaults, clears the region state and drops out_valid.
`default_nettype none

module masked_byte_pattern_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbps_pkg::DATA_W-1:0] pwdata,
  output logic      [mbps_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             found,
  output logic [63:0]                      match_address
);
  import mbps_pkg::*;

  cfg_t cfg;

  mbps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbps_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
  );

endmodule

`default_nettype wire

/* sv/mbps_regs.sv */
`default_nettype none

module mbps_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbps_pkg::DATA_W-1:0] pwdata,
  output logic      [mbps_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mbps_pkg::cfg_t                  cfg
);
  import mbps_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern <= '0;
      cfg.mask    <= '1;
      cfg.length  <= 6'd1;
      cfg.stride  <= 16'd1;
      cfg.base    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PAT0:   cfg.pattern[7:0]   <= pwdata;
        REG_PAT1:   cfg.pattern[15:8]  <= pwdata;
        REG_PAT2:   cfg.pattern[23:16] <= pwdata;
        REG_PAT3:   cfg.pattern[31:24] <= pwdata;
        REG_MASK:   cfg.mask           <= pwdata[PAT_BYTES-1:0];
        REG_LENGTH: cfg.length         <= pwdata[5:0];
        REG_STRIDE: cfg.stride         <= pwdata[15:0];
        REG_BASE:   cfg.base           <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      REG_PAT0:   prdata = cfg.pattern[7:0];
      REG_PAT1:   prdata = cfg.pattern[15:8];
      REG_PAT2:   prdata = cfg.pattern[23:16];
      REG_PAT3:   prdata = cfg.pattern[31:24];
      REG_MASK:   prdata = DATA_W'(cfg.mask);
      REG_LENGTH: prdata = DATA_W'(cfg.length);
      REG_STRIDE: prdata = DATA_W'(cfg.stride);
      REG_BASE:   prdata = cfg.base;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/mbps_match.sv */
`default_nettype none

module mbps_match (
  input  wire mbps_pkg::window_t              window,
  input  wire mbps_pkg::cfg_t                 cfg,
  input  wire logic [mbps_pkg::LEN_W-1:0]     len_m1,
  output logic                                hit
);
  import mbps_pkg::*;

  logic [MAX_PATTERN-1:0] ok;

  // Window entry i holds the byte that lines up with pattern byte len_m1 - i.
  // Entries past the pattern length and wildcard bytes always pass.
  always_comb begin
    logic [LEN_W-1:0] j;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      j = len_m1 - LEN_W'(i);
      if (LEN_W'(i) > len_m1 || i >= LEN_CAP) begin
        ok[i] = 1'b1;
      end else begin
        ok[i] = !cfg.mask[j] || (window[i] == cfg.pattern[j]);
      end
    end
  end

  assign hit = &ok;

endmodule

`default_nettype wire

/* sv/mbps_scan.sv */
`default_nettype none

module mbps_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mbps_pkg::cfg_t        cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  last_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       found,
  output logic [63:0]                match_address
);
  import mbps_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  window_t                byte_window;
  window_t                window_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [15:0]            stride_phase;
  logic                   match_done;

  logic [LEN_W-1:0]       len_m1;
  logic                   accept;
  logic                   testing;
  logic                   window_hit;
  logic                   hit;
  logic                   emit;
  logic [16:0]            phase_inc;
  logic [15:0]            phase_next;
  logic [OFFSET_BITS-1:0] start_offset;

  assign len_m1   = mbps_pkg::len_m1(cfg.length);
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Window as it stands once the new byte is shifted in, newest first.
  assign window_next = {byte_window[MAX_PATTERN-2:0], data_byte};

  mbps_match u_match (
    .window (window_next),
    .cfg    (cfg),
    .len_m1 (len_m1),
    .hit    (window_hit)
  );

  // A start is tested once the whole pattern has arrived behind it.
  assign testing   = (byte_position != POS_MAX) &&
                     (byte_position >= OFFSET_BITS'(len_m1));
  assign phase_inc = {1'b0, stride_phase} + 17'd1;
  assign phase_next = (phase_inc >= {1'b0, cfg.stride}) ? 16'd0 : phase_inc[15:0];
  assign hit       = !match_done && testing && (stride_phase == 16'd0) && window_hit;
  assign emit      = !match_done && (hit || last_byte);
  assign start_offset = byte_position - OFFSET_BITS'(len_m1);

  // Region state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      stride_phase  <= '0;
      match_done    <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position <= '0;
        stride_phase  <= '0;
        match_done    <= 1'b0;
      end else if (!match_done) begin
        if (testing) begin
          stride_phase <= phase_next;
        end
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + OFFSET_BITS'(1);
        end
        match_done <= hit;
      end
    end
  end

  // Window bytes are only read after a full pattern has entered, so no reset.
  always_ff @(posedge clk) begin
    if (accept && !match_done) begin
      byte_window <= window_next;
    end
  end

  // Result register; a new result loads when the old one is gone or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      found         <= hit;
      match_address <= hit ? (cfg.base + 64'(start_offset)) : 64'd0;
    end
  end

endmodule

`default_nettype wire

/* sv/mbps_checker.sv */
`default_nettype none

module mbps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        found,
  input wire logic [63:0] match_address
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_address))
    else $error("stalled result changed");

  // A no-match result carries a zero address.
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_address == 64'd0)
    else $error("no-match result with nonzero address");

  // The input side only stalls behind a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // An empty result register stays empty when no input transaction arrives.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !in_valid |=> !out_valid)
    else $error("result appeared without an input transaction");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found         (found),
  .match_address (match_address)
);

`default_nettype wire
